[sv/assert_macros.svh]
// assertion macros shared by the vertex rotate/project rtl
// expects a clock named clk and a synchronous reset named rst in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// checked on every clock edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLK_ALWAYS(label, prop, msg)
`endif
`endif

[sv/vrp_pkg.sv]
// shared types, constants and trig lookup for the vertex rotate/project pipeline
// no dependencies
package vrp_pkg;

  // angle handling
  localparam int ANGLE_STEPS = 360;
  localparam int QUARTER     = ANGLE_STEPS / 4;
  localparam int Q_BITS      = 14;

  // register indexes and reset values
  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_SCALE    = 2'd2;
  localparam logic [7:0] CENTER_X_RST = 8'd100;
  localparam logic [7:0] CENTER_Y_RST = 8'd80;
  localparam logic [6:0] SCALE_RST    = 7'd60;

  // datapath widths
  localparam int COORD_W = 9;
  localparam int TRIG_W  = 16;
  localparam int P1_W    = COORD_W + TRIG_W;   // coord times trig
  localparam int SUM1_W  = P1_W + 1;           // y1, z1
  localparam int Z1SY_W  = SUM1_W + TRIG_W;    // z1 times sin
  localparam int X2_W    = 40;                 // |x2| stays below 2^37
  localparam int BIG_W   = X2_W + TRIG_W;      // x2 times trig
  localparam int Y1P_W   = SUM1_W + TRIG_W;    // y1 times trig
  localparam int ROT_W   = 54;                 // |X|, |Y| stay below 2^51
  localparam int P_W     = ROT_W + 8;          // rotated times scale
  localparam int DIV_SHIFT   = 42;
  localparam int T_W         = 17;             // truncated magnitude
  localparam int DIVISOR     = 100;
  localparam int RECIP_SHIFT = 24;
  localparam logic [17:0] RECIP = 18'd167773;  // ceil(2^24 / 100)
  localparam int RP_W    = T_W + 18;
  localparam int Q_W     = RP_W - RECIP_SHIFT;
  localparam int OUT_W   = 11;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [8:0]                angle_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef struct packed {
    trig_t sin_v;
    trig_t cos_v;
  } trig_set_t;

  // round(16384 * sin(d degrees)), d = 0..90
  function automatic logic [14:0] quarter_sine(input logic [6:0] r);
    logic [14:0] v;
    case (r)
      7'd0: v = 15'd0;       7'd1: v = 15'd286;     7'd2: v = 15'd572;
      7'd3: v = 15'd857;     7'd4: v = 15'd1143;    7'd5: v = 15'd1428;
      7'd6: v = 15'd1713;    7'd7: v = 15'd1997;    7'd8: v = 15'd2280;
      7'd9: v = 15'd2563;    7'd10: v = 15'd2845;   7'd11: v = 15'd3126;
      7'd12: v = 15'd3406;   7'd13: v = 15'd3686;   7'd14: v = 15'd3964;
      7'd15: v = 15'd4240;   7'd16: v = 15'd4516;   7'd17: v = 15'd4790;
      7'd18: v = 15'd5063;   7'd19: v = 15'd5334;   7'd20: v = 15'd5604;
      7'd21: v = 15'd5872;   7'd22: v = 15'd6138;   7'd23: v = 15'd6402;
      7'd24: v = 15'd6664;   7'd25: v = 15'd6924;   7'd26: v = 15'd7182;
      7'd27: v = 15'd7438;   7'd28: v = 15'd7692;   7'd29: v = 15'd7943;
      7'd30: v = 15'd8192;   7'd31: v = 15'd8438;   7'd32: v = 15'd8682;
      7'd33: v = 15'd8923;   7'd34: v = 15'd9162;   7'd35: v = 15'd9397;
      7'd36: v = 15'd9630;   7'd37: v = 15'd9860;   7'd38: v = 15'd10087;
      7'd39: v = 15'd10311;  7'd40: v = 15'd10531;  7'd41: v = 15'd10749;
      7'd42: v = 15'd10963;  7'd43: v = 15'd11174;  7'd44: v = 15'd11381;
      7'd45: v = 15'd11585;  7'd46: v = 15'd11786;  7'd47: v = 15'd11982;
      7'd48: v = 15'd12176;  7'd49: v = 15'd12365;  7'd50: v = 15'd12551;
      7'd51: v = 15'd12733;  7'd52: v = 15'd12910;  7'd53: v = 15'd13084;
      7'd54: v = 15'd13255;  7'd55: v = 15'd13421;  7'd56: v = 15'd13583;
      7'd57: v = 15'd13741;  7'd58: v = 15'd13894;  7'd59: v = 15'd14044;
      7'd60: v = 15'd14189;  7'd61: v = 15'd14330;  7'd62: v = 15'd14466;
      7'd63: v = 15'd14598;  7'd64: v = 15'd14726;  7'd65: v = 15'd14849;
      7'd66: v = 15'd14968;  7'd67: v = 15'd15082;  7'd68: v = 15'd15191;
      7'd69: v = 15'd15296;  7'd70: v = 15'd15396;  7'd71: v = 15'd15491;
      7'd72: v = 15'd15582;  7'd73: v = 15'd15668;  7'd74: v = 15'd15749;
      7'd75: v = 15'd15826;  7'd76: v = 15'd15897;  7'd77: v = 15'd15964;
      7'd78: v = 15'd16026;  7'd79: v = 15'd16083;  7'd80: v = 15'd16135;
      7'd81: v = 15'd16182;  7'd82: v = 15'd16225;  7'd83: v = 15'd16262;
      7'd84: v = 15'd16294;  7'd85: v = 15'd16322;  7'd86: v = 15'd16344;
      7'd87: v = 15'd16362;  7'd88: v = 15'd16374;  7'd89: v = 15'd16382;
      7'd90: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // fold a raw 9-bit angle into 0..359
  function automatic angle_t reduce_angle(input angle_t raw);
    return (raw >= 9'(ANGLE_STEPS)) ? raw - 9'(ANGLE_STEPS) : raw;
  endfunction

  // angle plus a quarter turn, folded into 0..359
  function automatic angle_t quarter_on(input angle_t a);
    logic [9:0] s;
    s = {1'b0, a} + 10'(QUARTER);
    return (s >= 10'(ANGLE_STEPS)) ? 9'(s - 10'(ANGLE_STEPS)) : 9'(s);
  endfunction

  // sine in Q2.14 of a reduced angle by quadrant folding
  function automatic trig_t sin_q14(input angle_t a);
    angle_t      r;
    logic        neg;
    logic [14:0] m;
    if (a < 9'(QUARTER)) begin
      r = a;
      neg = 1'b0;
    end else if (a < 9'(2 * QUARTER)) begin
      r = 9'(2 * QUARTER) - a;
      neg = 1'b0;
    end else if (a < 9'(3 * QUARTER)) begin
      r = a - 9'(2 * QUARTER);
      neg = 1'b1;
    end else begin
      r = 9'(ANGLE_STEPS) - a;
      neg = 1'b1;
    end
    m = quarter_sine(r[6:0]);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

[sv/vrp_trig.sv]
// first pipeline stage: angle reduction and sine/cosine table lookup
// depends on vrp_pkg
module vrp_trig (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_valid,
  input  vrp_pkg::vertex_t    in_vert,
  input  vrp_pkg::angle_t     angle_x,
  input  vrp_pkg::angle_t     angle_y,
  input  vrp_pkg::angle_t     angle_z,
  output logic                out_valid,
  output vrp_pkg::vertex_t    out_vert,
  output vrp_pkg::trig_set_t  trig_x,
  output vrp_pkg::trig_set_t  trig_y,
  output vrp_pkg::trig_set_t  trig_z
);

  vrp_pkg::angle_t ax, ay, az;

  // reduce angles into one turn
  always_comb begin
    ax = vrp_pkg::reduce_angle(angle_x);
    ay = vrp_pkg::reduce_angle(angle_y);
    az = vrp_pkg::reduce_angle(angle_z);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= in_valid;
    end
  end

  // table lookups, cosine as sine a quarter turn on
  always_ff @(posedge clk) begin
    if (ce) begin
      out_vert     <= in_vert;
      trig_x.sin_v <= vrp_pkg::sin_q14(ax);
      trig_x.cos_v <= vrp_pkg::sin_q14(vrp_pkg::quarter_on(ax));
      trig_y.sin_v <= vrp_pkg::sin_q14(ay);
      trig_y.cos_v <= vrp_pkg::sin_q14(vrp_pkg::quarter_on(ay));
      trig_z.sin_v <= vrp_pkg::sin_q14(az);
      trig_z.cos_v <= vrp_pkg::sin_q14(vrp_pkg::quarter_on(az));
    end
  end

endmodule

[sv/vrp_rotate.sv]
// six-stage exact rotation about x, then y (x only), then z
// depends on vrp_pkg; fed by vrp_trig
module vrp_rotate (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   ce,
  input  logic                                   in_valid,
  input  vrp_pkg::vertex_t                       in_vert,
  input  vrp_pkg::trig_set_t                     trig_x,
  input  vrp_pkg::trig_set_t                     trig_y,
  input  vrp_pkg::trig_set_t                     trig_z,
  output logic                                   out_valid,
  output logic signed [vrp_pkg::ROT_W-1:0]       rot_x,
  output logic signed [vrp_pkg::ROT_W-1:0]       rot_y
);

  logic [5:0] v;

  // stage 1 products
  logic signed [vrp_pkg::P1_W-1:0] ycx, zsx, ysx, zcx, xcy;
  vrp_pkg::trig_t sy1, sz1, cz1;
  // stage 2 sums
  logic signed [vrp_pkg::SUM1_W-1:0] y1_2, z1_2;
  logic signed [vrp_pkg::P1_W-1:0]   xcy2;
  vrp_pkg::trig_t sy2, sz2, cz2;
  // stage 3 product
  logic signed [vrp_pkg::Z1SY_W-1:0] z1sy3;
  logic signed [vrp_pkg::SUM1_W-1:0] y1_3;
  logic signed [vrp_pkg::P1_W-1:0]   xcy3;
  vrp_pkg::trig_t sz3, cz3;
  // stage 4 x after y rotation
  logic signed [vrp_pkg::X2_W-1:0]   x2_4;
  logic signed [vrp_pkg::SUM1_W-1:0] y1_4;
  vrp_pkg::trig_t sz4, cz4;
  // stage 5 products of z rotation
  logic signed [vrp_pkg::BIG_W-1:0]  x2cz, x2sz;
  logic signed [vrp_pkg::Y1P_W-1:0]  y1sz, y1cz;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[4:0], in_valid};
    end
  end

  assign out_valid = v[5];

  always_ff @(posedge clk) begin
    if (ce) begin
      // rotation about x: products
      ycx <= vrp_pkg::P1_W'(in_vert.y) * vrp_pkg::P1_W'(trig_x.cos_v);
      zsx <= vrp_pkg::P1_W'(in_vert.z) * vrp_pkg::P1_W'(trig_x.sin_v);
      ysx <= vrp_pkg::P1_W'(in_vert.y) * vrp_pkg::P1_W'(trig_x.sin_v);
      zcx <= vrp_pkg::P1_W'(in_vert.z) * vrp_pkg::P1_W'(trig_x.cos_v);
      xcy <= vrp_pkg::P1_W'(in_vert.x) * vrp_pkg::P1_W'(trig_y.cos_v);
      sy1 <= trig_y.sin_v;
      sz1 <= trig_z.sin_v;
      cz1 <= trig_z.cos_v;

      // rotation about x: sums
      y1_2 <= vrp_pkg::SUM1_W'(ycx) - vrp_pkg::SUM1_W'(zsx);
      z1_2 <= vrp_pkg::SUM1_W'(ysx) + vrp_pkg::SUM1_W'(zcx);
      xcy2 <= xcy;
      sy2  <= sy1;
      sz2  <= sz1;
      cz2  <= cz1;

      // rotation about y: z1 term
      z1sy3 <= vrp_pkg::Z1SY_W'(z1_2) * vrp_pkg::Z1SY_W'(sy2);
      y1_3  <= y1_2;
      xcy3  <= xcy2;
      sz3   <= sz2;
      cz3   <= cz2;

      // rotation about y: new x at scale 2^28
      x2_4 <= vrp_pkg::X2_W'((vrp_pkg::Z1SY_W'(xcy3) <<< vrp_pkg::Q_BITS) + z1sy3);
      y1_4 <= y1_3;
      sz4  <= sz3;
      cz4  <= cz3;

      // rotation about z: products
      x2cz <= vrp_pkg::BIG_W'(x2_4) * vrp_pkg::BIG_W'(cz4);
      x2sz <= vrp_pkg::BIG_W'(x2_4) * vrp_pkg::BIG_W'(sz4);
      y1sz <= vrp_pkg::Y1P_W'(y1_4) * vrp_pkg::Y1P_W'(sz4);
      y1cz <= vrp_pkg::Y1P_W'(y1_4) * vrp_pkg::Y1P_W'(cz4);

      // rotation about z: sums at scale 2^42
      rot_x <= vrp_pkg::ROT_W'(x2cz - (vrp_pkg::BIG_W'(y1sz) <<< vrp_pkg::Q_BITS));
      rot_y <= vrp_pkg::ROT_W'(x2sz + (vrp_pkg::BIG_W'(y1cz) <<< vrp_pkg::Q_BITS));
    end
  end

endmodule

[sv/vrp_project.sv]
// four-stage projection of one axis: scale, truncating divide by 100 * 2^42, center
// depends on vrp_pkg and assert_macros.svh
`include "assert_macros.svh"

module vrp_project (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   ce,
  input  logic                                   in_valid,
  input  logic signed [vrp_pkg::ROT_W-1:0]       rot,
  input  logic [6:0]                             scale,
  input  logic [7:0]                             center,
  output logic                                   out_valid,
  output logic signed [vrp_pkg::OUT_W-1:0]       screen
);

  logic [3:0] v;

  logic signed [vrp_pkg::P_W-1:0] prod1;
  logic [vrp_pkg::P_W-1:0]        mag;
  logic [vrp_pkg::T_W-1:0]        t2, t3;
  logic                           neg2, neg3;
  logic [vrp_pkg::RP_W-1:0]       recip3;
  logic [vrp_pkg::Q_W-1:0]        quo;
  logic [vrp_pkg::OUT_W-1:0]      sum4;
  logic [vrp_pkg::T_W:0]          quo_floor;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[2:0], in_valid};
    end
  end

  assign out_valid = v[3];

  // magnitude of the scaled value
  assign mag = prod1[vrp_pkg::P_W-1] ? vrp_pkg::P_W'(-prod1) : vrp_pkg::P_W'(prod1);

  // quotient by 100 via reciprocal, exact for magnitudes below 2^17
  assign quo = recip3[vrp_pkg::RP_W-1 -: vrp_pkg::Q_W];

  always_ff @(posedge clk) begin
    if (ce) begin
      // multiply by scale
      prod1 <= vrp_pkg::P_W'(rot) * vrp_pkg::P_W'($signed({1'b0, scale}));

      // drop the 2^42 fraction, keep the sign apart
      t2   <= mag[vrp_pkg::DIV_SHIFT +: vrp_pkg::T_W];
      neg2 <= prod1[vrp_pkg::P_W-1];

      // multiply by reciprocal of 100
      recip3 <= vrp_pkg::RP_W'(t2) * vrp_pkg::RP_W'(vrp_pkg::RECIP);
      t3     <= t2;
      neg3   <= neg2;

      // restore sign and add center
      screen <= $signed(vrp_pkg::OUT_W'(center) + (neg3 ? vrp_pkg::OUT_W'(-quo) : quo));
    end
  end

  assign quo_floor = (vrp_pkg::T_W + 1)'(quo) * (vrp_pkg::T_W + 1)'(vrp_pkg::DIVISOR);

  // checks
  `ASSERT_CLK(a_quotient_exact, v[2] |-> (quo_floor <= (vrp_pkg::T_W + 1)'(t3)) && ((vrp_pkg::T_W + 1)'(t3) < quo_floor + (vrp_pkg::T_W + 1)'(vrp_pkg::DIVISOR)), "reciprocal divide off by one")
  `ASSERT_CLK(a_valid_advance, !rst && ce |=> v[3:1] == $past(v[2:0]), "valid bit lost in advance")
  `ASSERT_CLK(a_valid_hold, !rst && !ce |=> $stable(v), "valid bits moved during stall")

endmodule

[sv/vertex_rotate_project_top.sv]
// throughput: one vertex per cycle while m_tready does not stall; 1 trig stage, 6 rotate stages, 4 project stages
// a stall on m_tready freezes every stage at once, the last stage is the output register
// reset clears all valid bits and loads center_x 100, center_y 80, scale 60
// depends on vrp_pkg, vrp_trig, vrp_rotate, vrp_project, assert_macros.svh
`include "assert_macros.svh"

module vertex_rotate_project_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // vert_x[8:0], vert_y[17:9], vert_z[26:18], angle_x[35:27], angle_y[44:36],
  // angle_z[53:45], zero fill[55:54]
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // screen_x[10:0], screen_y[21:11], zero fill[23:22]
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] center_x, center_y;
  logic [6:0] scale;
  logic       ce;

  vrp_pkg::vertex_t   in_vert, t_vert;
  vrp_pkg::trig_set_t trig_x, trig_y, trig_z;
  logic               t_valid, r_valid, px_valid, py_valid;
  logic signed [vrp_pkg::ROT_W-1:0] rot_x, rot_y;
  logic signed [vrp_pkg::OUT_W-1:0] screen_x, screen_y;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= vrp_pkg::CENTER_X_RST;
      center_y <= vrp_pkg::CENTER_Y_RST;
      scale    <= vrp_pkg::SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vrp_pkg::REG_CENTER_X: center_x <= cfg_data;
        vrp_pkg::REG_CENTER_Y: center_y <= cfg_data;
        vrp_pkg::REG_SCALE:    scale    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances when the output register is free or being taken
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // unpack the input word
  assign in_vert.x = $signed(s_tdata[8:0]);
  assign in_vert.y = $signed(s_tdata[17:9]);
  assign in_vert.z = $signed(s_tdata[26:18]);

  vrp_trig u_trig (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .in_vert   (in_vert),
    .angle_x   (s_tdata[35:27]),
    .angle_y   (s_tdata[44:36]),
    .angle_z   (s_tdata[53:45]),
    .out_valid (t_valid),
    .out_vert  (t_vert),
    .trig_x    (trig_x),
    .trig_y    (trig_y),
    .trig_z    (trig_z)
  );

  vrp_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (t_valid),
    .in_vert   (t_vert),
    .trig_x    (trig_x),
    .trig_y    (trig_y),
    .trig_z    (trig_z),
    .out_valid (r_valid),
    .rot_x     (rot_x),
    .rot_y     (rot_y)
  );

  vrp_project u_project_x (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (r_valid),
    .rot       (rot_x),
    .scale     (scale),
    .center    (center_x),
    .out_valid (px_valid),
    .screen    (screen_x)
  );

  vrp_project u_project_y (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (r_valid),
    .rot       (rot_y),
    .scale     (scale),
    .center    (center_y),
    .out_valid (py_valid),
    .screen    (screen_y)
  );

  // pack the output word
  assign m_tvalid = px_valid;
  assign m_tdata  = {2'b00, screen_y, screen_x};

  // checks
  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output word valid right after reset")
  `ASSERT_CLK(a_axes_aligned, px_valid == py_valid, "x and y projection lanes out of step")

endmodule
